@@ hw/rtl/qwd_pkg.sv @@
// Package for the four-wheel quadrature decoder: sizes, payload structs and
// the control struct shared by the decoder's modules. No dependencies.
`default_nettype none

package qwd_pkg;

  // Counter geometry.
  localparam int unsigned CountW    = 16;
  localparam int unsigned NumWheels = 4;

  // Width of a reported count field and number of reported wheel slots.
  localparam int unsigned FieldW    = 16;
  localparam int unsigned NumSlots  = 4;
  localparam int unsigned MaskW     = 4;

  // Width used to negate and clamp a count before it is reported.
  localparam int unsigned CmpW      = CountW + FieldW + 2;

  // Item function codes.
  typedef enum logic {
    FUNC_SAMPLE = 1'b0,
    FUNC_READ   = 1'b1
  } func_e;

  typedef struct packed {
    logic             func;
    logic [MaskW-1:0] pins_a;
    logic [MaskW-1:0] pins_b;
  } in_item_t;

  typedef struct packed {
    logic signed [FieldW-1:0] count_front_left;
    logic signed [FieldW-1:0] count_front_right;
    logic signed [FieldW-1:0] count_back_left;
    logic signed [FieldW-1:0] count_back_right;
    logic [NumSlots-1:0]      overflow_bits;
    logic [NumSlots-1:0]      error_bits;
  } out_item_t;

  // Per-cycle command from the top level to each wheel.
  typedef struct packed {
    logic sample;  // an accepted pin sample that is compared with the last one
    logic clear;   // an accepted read: counts and flags return to zero
  } wheel_ctrl_t;

endpackage

`default_nettype wire

@@ hw/rtl/qwd_wheel.sv @@
// One wheel of the quadrature decoder: x4 edge decode, saturating signed
// counter and sticky overflow and error flags. Uses qwd_pkg.
`default_nettype none

module qwd_wheel (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire qwd_pkg::wheel_ctrl_t        ctrl_i,
  input  wire logic                        pin_a_i,
  input  wire logic                        pin_b_i,
  input  wire logic                        last_a_i,
  input  wire logic                        last_b_i,
  output logic signed [qwd_pkg::CountW-1:0] count_o,
  output logic                             ovf_o,
  output logic                             err_o
);

  localparam logic signed [qwd_pkg::CountW-1:0] CountMax =
    {1'b0, {(qwd_pkg::CountW-1){1'b1}}};
  localparam logic signed [qwd_pkg::CountW-1:0] CountMin =
    {1'b1, {(qwd_pkg::CountW-1){1'b0}}};
  localparam logic signed [qwd_pkg::CountW-1:0] CountInc =
    {{(qwd_pkg::CountW-1){1'b0}}, 1'b1};
  localparam logic signed [qwd_pkg::CountW-1:0] CountDec =
    {qwd_pkg::CountW{1'b1}};

  logic signed [qwd_pkg::CountW-1:0] count_q, count_d;
  logic ovf_q, ovf_d;
  logic err_q, err_d;
  logic chg_a, chg_b, up, at_limit;

  assign chg_a = pin_a_i != last_a_i;
  assign chg_b = pin_b_i != last_b_i;
  // Forward order is 00 -> 10 -> 11 -> 01, so phase A leads phase B.
  assign up = chg_a ? (pin_a_i != pin_b_i) : (pin_b_i == pin_a_i);
  assign at_limit = up ? (count_q == CountMax) : (count_q == CountMin);

  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    err_d   = err_q;
    if (ctrl_i.clear) begin
      count_d = '0;
      ovf_d   = 1'b0;
      err_d   = 1'b0;
    end else if (ctrl_i.sample) begin
      if (chg_a && chg_b) begin
        err_d = 1'b1;
      end else if (chg_a || chg_b) begin
        if (at_limit) begin
          ovf_d = 1'b1;
        end else begin
          count_d = count_q + (up ? CountInc : CountDec);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
      err_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      ovf_q   <= ovf_d;
      err_q   <= err_d;
    end
  end

  assign count_o = count_q;
  assign ovf_o   = ovf_q;
  assign err_o   = err_q;

endmodule

`default_nettype wire

@@ hw/rtl/qwd_report.sv @@
// Builds a read result: applies the invert mask to each count, clamps it to
// the report field and gathers the flags. Uses qwd_pkg.
`default_nettype none

module qwd_report (
  input  wire logic [qwd_pkg::NumWheels-1:0][qwd_pkg::CountW-1:0] counts_i,
  input  wire logic [qwd_pkg::MaskW-1:0]                          invert_i,
  input  wire logic [qwd_pkg::NumWheels-1:0]                      ovf_i,
  input  wire logic [qwd_pkg::NumWheels-1:0]                      err_i,
  output qwd_pkg::out_item_t                                      result_o
);

  localparam logic signed [qwd_pkg::CmpW-1:0] FieldMax =
    qwd_pkg::CmpW'((64'sd1 <<< (qwd_pkg::FieldW - 1)) - 64'sd1);
  localparam logic signed [qwd_pkg::CmpW-1:0] FieldMin = -FieldMax - 1;

  logic signed [qwd_pkg::FieldW-1:0] vals [qwd_pkg::NumSlots];
  logic [qwd_pkg::NumSlots-1:0] clamp_ovf;
  logic [qwd_pkg::NumSlots-1:0] ovf_slot;
  logic [qwd_pkg::NumSlots-1:0] err_slot;

  for (genvar w = 0; w < qwd_pkg::NumSlots; w++) begin : g_slot
    if (w < qwd_pkg::NumWheels) begin : g_present
      logic signed [qwd_pkg::CmpW-1:0] ext, val;
      always_comb begin
        ext = qwd_pkg::CmpW'($signed(counts_i[w]));
        val = invert_i[w] ? -ext : ext;
        clamp_ovf[w] = 1'b0;
        if (val > FieldMax) begin
          vals[w] = FieldMax[qwd_pkg::FieldW-1:0];
          clamp_ovf[w] = 1'b1;
        end else if (val < FieldMin) begin
          vals[w] = FieldMin[qwd_pkg::FieldW-1:0];
          clamp_ovf[w] = 1'b1;
        end else begin
          vals[w] = val[qwd_pkg::FieldW-1:0];
        end
      end
      assign ovf_slot[w] = ovf_i[w] | clamp_ovf[w];
      assign err_slot[w] = err_i[w];
    end else begin : g_absent
      assign vals[w]      = '0;
      assign clamp_ovf[w] = 1'b0;
      assign ovf_slot[w]  = 1'b0;
      assign err_slot[w]  = 1'b0;
    end
  end

  always_comb begin
    result_o.count_front_left  = vals[0];
    result_o.count_front_right = vals[1];
    result_o.count_back_left   = vals[2];
    result_o.count_back_right  = vals[3];
    result_o.overflow_bits     = ovf_slot;
    result_o.error_bits        = err_slot;
  end

endmodule

`default_nettype wire

@@ hw/rtl/quad_wheel_quadrature_decoder_core.sv @@
// Four-wheel x4 quadrature decoder, top level. A read result shows on the
// output in the cycle after the read is accepted; pin samples give none.
// One item is accepted per cycle while the single output register is empty
// or its result is taken. Reset clears counts, flags, the stored pin levels
// and the output valid, and loads the invert mask with 4'b1010. Uses qwd_pkg.
`default_nettype none

module quad_wheel_quadrature_decoder_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Configuration: invert mask.
  input  wire logic                         cfg_we_i,
  input  wire logic [qwd_pkg::MaskW-1:0]    cfg_data_i,
  // Input items.
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire qwd_pkg::in_item_t            in_data_i,
  // Result items.
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output qwd_pkg::out_item_t                out_data_o
);

  logic [qwd_pkg::MaskW-1:0] invert_q;
  logic [qwd_pkg::MaskW-1:0] last_a_q, last_b_q;
  logic                      seen_q;
  logic                      out_valid_q, out_valid_d;
  qwd_pkg::out_item_t        out_q;

  logic in_xfer, is_read, is_sample;
  qwd_pkg::wheel_ctrl_t ctrl;

  logic [qwd_pkg::NumWheels-1:0][qwd_pkg::CountW-1:0] counts;
  logic [qwd_pkg::NumWheels-1:0] ovf, err;
  qwd_pkg::out_item_t result;

  // The output register frees up in the same cycle its result is taken, so a
  // new item can be accepted every cycle while results keep flowing.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign is_read    = in_xfer && (in_data_i.func == qwd_pkg::FUNC_READ);
  assign is_sample  = in_xfer && (in_data_i.func == qwd_pkg::FUNC_SAMPLE);

  // The first sample after reset only captures the pin levels.
  assign ctrl.sample = is_sample && seen_q;
  assign ctrl.clear  = is_read;

  for (genvar w = 0; w < qwd_pkg::NumWheels; w++) begin : g_wheel
    logic signed [qwd_pkg::CountW-1:0] cnt;
    qwd_wheel u_wheel (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .pin_a_i  (in_data_i.pins_a[w]),
      .pin_b_i  (in_data_i.pins_b[w]),
      .last_a_i (last_a_q[w]),
      .last_b_i (last_b_q[w]),
      .count_o  (cnt),
      .ovf_o    (ovf[w]),
      .err_o    (err[w])
    );
    assign counts[w] = cnt;
  end

  // The read result is built from the state before the read clears it.
  qwd_report u_report (
    .counts_i (counts),
    .invert_i (invert_q),
    .ovf_i    (ovf),
    .err_i    (err),
    .result_o (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (is_read) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      invert_q    <= 4'b1010;
      last_a_q    <= '0;
      last_b_q    <= '0;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        invert_q <= cfg_data_i;
      end
      // A read leaves the stored pin levels alone.
      if (is_sample) begin
        last_a_q <= in_data_i.pins_a;
        last_b_q <= in_data_i.pins_b;
        seen_q   <= 1'b1;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_read) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

@@ hw/rtl/qwd_checker.sv @@
// Port-level checker for the quadrature decoder top level, with the bind
// that attaches it. Uses qwd_pkg and quad_wheel_quadrature_decoder_core.
`default_nettype none

module qwd_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire qwd_pkg::in_item_t  in_data_i,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire qwd_pkg::out_item_t out_data_o
);

  logic rd_xfer, other_xfer;

  assign rd_xfer    = in_valid_i && in_ready_o && (in_data_i.func == qwd_pkg::FUNC_READ);
  assign other_xfer = !rd_xfer && (!out_valid_o || out_ready_i);

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // Every accepted read transfer produces a result in the next cycle.
  a_read_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_xfer |=> out_valid_o)
    else $error("read transfer gave no result");

  // Without a read transfer, a drained output stays empty.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    other_xfer |=> !out_valid_o)
    else $error("result appeared without a read");

  // Two reads back to back: the second one sees cleared state.
  a_read_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_xfer ##1 rd_xfer |=> out_data_o.count_front_left == '0
      && out_data_o.count_front_right == '0 && out_data_o.count_back_left == '0
      && out_data_o.count_back_right == '0 && out_data_o.overflow_bits == '0
      && out_data_o.error_bits == '0)
    else $error("read did not clear counts and flags");

endmodule

bind quad_wheel_quadrature_decoder_core qwd_checker u_qwd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

@@ test/qwd_count_checker.sv @@
// Checker for the quadrature decoder: watches the config, input and result
// channels, predicts each read report and compares it field by field.
// Depends on qwd_pkg for the payload types and sizes.
`timescale 1ns / 100ps

module qwd_count_checker
  import qwd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [MaskW-1:0]    cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  in_item_t            in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  out_item_t           out_data_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  localparam logic [MaskW-1:0] MASK_AT_RESET = 4'b1010;
  localparam longint CNT_MAX   = (longint'(1) << (CountW - 1)) - 1;
  localparam longint CNT_MIN   = -CNT_MAX - 1;
  localparam longint FIELD_MAX = (longint'(1) << (FieldW - 1)) - 1;
  localparam longint FIELD_MIN = -FIELD_MAX - 1;

  // Predicted decoder state.
  logic [MaskW-1:0]    invert_mask;
  logic [MaskW-1:0]    prev_a;
  logic [MaskW-1:0]    prev_b;
  logic                primed;
  longint              wheel_cnt [NumWheels];
  logic [NumSlots-1:0] ovf_sticky;
  logic [NumSlots-1:0] err_sticky;

  out_item_t expected_reports [$];
  int        mismatches;

  function automatic void nudge_count(int w, int dir);
    longint nxt;
    nxt = wheel_cnt[w] + dir;
    if (nxt > CNT_MAX || nxt < CNT_MIN) begin
      ovf_sticky[w] = 1'b1;
    end else begin
      wheel_cnt[w] = nxt;
    end
  endfunction

  // A lone A edge counts up when A and B now differ; a lone B edge counts up
  // when they now agree. Both edges at once count nothing and flag an error.
  function automatic void decode_sample(logic [MaskW-1:0] a, logic [MaskW-1:0] b);
    logic ca;
    logic cb;
    if (primed) begin
      for (int w = 0; w < NumWheels && w < MaskW; w++) begin
        ca = a[w] != prev_a[w];
        cb = b[w] != prev_b[w];
        if (ca && cb) begin
          err_sticky[w] = 1'b1;
        end else if (ca) begin
          nudge_count(w, (a[w] != b[w]) ? 1 : -1);
        end else if (cb) begin
          nudge_count(w, (a[w] == b[w]) ? 1 : -1);
        end
      end
    end
    prev_a = a;
    prev_b = b;
    primed = 1'b1;
  endfunction

  function automatic void clear_counts();
    for (int w = 0; w < NumWheels; w++) begin
      wheel_cnt[w] = 0;
    end
    ovf_sticky = '0;
    err_sticky = '0;
  endfunction

  // Report with inversion and clamping to the field, then clear.
  function automatic out_item_t report_counts();
    out_item_t           rep;
    longint              v;
    logic [FieldW-1:0]   field [NumSlots];
    logic [NumSlots-1:0] ovf_rep;
    ovf_rep = ovf_sticky;
    for (int w = 0; w < NumSlots; w++) begin
      v = 0;
      if (w < NumWheels) begin
        v = wheel_cnt[w];
        if (invert_mask[w]) begin
          v = -v;
        end
        if (v > FIELD_MAX) begin
          v = FIELD_MAX;
          ovf_rep[w] = 1'b1;
        end else if (v < FIELD_MIN) begin
          v = FIELD_MIN;
          ovf_rep[w] = 1'b1;
        end
      end
      field[w] = v[FieldW-1:0];
    end
    rep.count_front_left  = field[0];
    rep.count_front_right = field[1];
    rep.count_back_left   = field[2];
    rep.count_back_right  = field[3];
    rep.overflow_bits     = ovf_rep;
    rep.error_bits        = err_sticky;
    clear_counts();
    return rep;
  endfunction

  function automatic void check_field(string name, logic [FieldW-1:0] want,
                                      logic [FieldW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name,
               $signed(want), $signed(got));
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      invert_mask = MASK_AT_RESET;
      prev_a      = '0;
      prev_b      = '0;
      primed      = 1'b0;
      clear_counts();
      expected_reports.delete();
      mismatches  = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        invert_mask = cfg_data_i;
      end
      // A result leaving now belongs to a read accepted earlier.
      if (out_valid_i && out_ready_i) begin
        if (expected_reports.size() == 0) begin
          $display("%0t: unexpected report, expected none, actual %p", $time, out_data_i);
          mismatches++;
        end else begin
          want = expected_reports.pop_front();
          check_field("count_front_left", want.count_front_left,
                      out_data_i.count_front_left);
          check_field("count_front_right", want.count_front_right,
                      out_data_i.count_front_right);
          check_field("count_back_left", want.count_back_left,
                      out_data_i.count_back_left);
          check_field("count_back_right", want.count_back_right,
                      out_data_i.count_back_right);
          check_field("overflow_bits", FieldW'(want.overflow_bits),
                      FieldW'(out_data_i.overflow_bits));
          check_field("error_bits", FieldW'(want.error_bits),
                      FieldW'(out_data_i.error_bits));
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (in_data_i.func == FUNC_READ) begin
          expected_reports.push_back(report_counts());
        end else begin
          decode_sample(in_data_i.pins_a, in_data_i.pins_b);
        end
      end
      fail_count_o <= mismatches;
      pending_o    <= expected_reports.size();
    end
  end

endmodule

@@ test/tb_quad_wheel_quadrature_decoder_core.sv @@
// Testbench top for the four-wheel quadrature decoder: clock, reset, stimulus
// and verdict. Depends on qwd_pkg, the decoder core and qwd_count_checker.
`timescale 1ns / 100ps

module tb_quad_wheel_quadrature_decoder_core;
  import qwd_pkg::*;

  // Long receiver hold-off used to back the decoder up into its input.
  localparam int HOLD_CYCLES   = 300;
  // Cycles without any transfer before the run is declared hung.
  localparam int STALL_LIMIT   = 2000;
  localparam int PHASE_ITEMS   = 250;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we;
  logic [MaskW-1:0] cfg_data;
  logic             in_valid;
  logic             in_ready;
  in_item_t         in_data;
  logic             out_valid;
  logic             out_ready;
  out_item_t        out_data;

  int fail_count;
  int pending;

  // Idle percentages of the two sides, changed between phases.
  int send_idle_pct;
  int recv_idle_pct;

  // The stimulus asks for a hold-off by bumping hold_asked; the receiver
  // process serves it and counts the cycles on its own.
  int hold_asked;
  int hold_served;

  int stall_cycles;

  // Phase levels as last driven, so that legal steps can be built from them.
  logic [MaskW-1:0] pin_a;
  logic [MaskW-1:0] pin_b;

  quad_wheel_quadrature_decoder_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  qwd_count_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: random stalls at the current rate, or a long hold-off on
  // request. Every step gets exactly one update of out_ready.
  initial begin
    out_ready   = 1'b0;
    hold_served = 0;
    forever begin
      @(posedge clk_i);
      if (hold_asked != hold_served) begin
        hold_served++;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: a run that stops moving transfers has hung.
  initial stall_cycles = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Offers one item and returns at the edge where it is transferred. Valid
  // is left high so that back-to-back items follow with no idle gap; the next
  // call either lowers it for an idle gap or replaces the payload.
  task automatic send_item(input logic func, input logic [MaskW-1:0] a,
                           input logic [MaskW-1:0] b);
    in_item_t item;
    item.func   = func;
    item.pins_a = a;
    item.pins_b = b;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk_i); while (!in_ready);
  endtask

  task automatic sample_pins(input logic [MaskW-1:0] a, input logic [MaskW-1:0] b);
    pin_a = a;
    pin_b = b;
    send_item(FUNC_SAMPLE, a, b);
  endtask

  // Pin fields carry random junk on a read; the decoder must ignore them.
  task automatic read_counts();
    send_item(FUNC_READ, MaskW'($urandom), MaskW'($urandom));
  endtask

  // Moves each wheel one x4 step forward or backward, or flips both phases
  // at once (an illegal jump). Forward runs 00 -> 10 -> 11 -> 01 -> 00.
  task automatic step_wheels(input logic [MaskW-1:0] fwd, input logic [MaskW-1:0] bwd,
                             input logic [MaskW-1:0] both);
    logic [MaskW-1:0] a;
    logic [MaskW-1:0] b;
    a = pin_a;
    b = pin_b;
    for (int w = 0; w < MaskW; w++) begin
      if (both[w]) begin
        a[w] = ~a[w];
        b[w] = ~b[w];
      end else if (fwd[w]) begin
        if (a[w] == b[w]) a[w] = ~a[w];
        else b[w] = ~b[w];
      end else if (bwd[w]) begin
        if (a[w] == b[w]) b[w] = ~b[w];
        else a[w] = ~a[w];
      end
    end
    sample_pins(a, b);
  endtask

  // The mask is only changed with the decoder idle: input dropped, every
  // report collected, then a wait for the single output register to settle.
  task automatic write_mask(input logic [MaskW-1:0] value);
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  // Mostly legal motion with random direction per wheel, with reads mixed
  // in, and some noise: arbitrary pin jumps, double edges and repeats.
  task automatic random_item();
    int               pick;
    logic [MaskW-1:0] fwd;
    pick = $urandom_range(99);
    fwd  = MaskW'($urandom);
    if (pick < 12) begin
      read_counts();
    end else if (pick < 20) begin
      sample_pins(MaskW'($urandom), MaskW'($urandom));
    end else if (pick < 25) begin
      step_wheels('0, '0, MaskW'($urandom));
    end else if (pick < 29) begin
      sample_pins(pin_a, pin_b);
    end else begin
      step_wheels(fwd, MaskW'($urandom) & ~fwd, '0);
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    in_data       = '0;
    send_idle_pct = 32;
    recv_idle_pct = 55;
    hold_asked    = 0;
    pin_a         = '0;
    pin_b         = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, invert mask still at its reset value. The first sample
    // after reset differs from the cleared levels but must count nothing.
    sample_pins(4'hF, 4'h0);
    read_counts();
    // A full forward cycle on every wheel, then one step back.
    repeat (4) step_wheels(4'hF, 4'h0, 4'h0);
    step_wheels(4'h0, 4'hF, 4'h0);
    read_counts();
    // Mixed directions, then double edges that only flag errors, and steps.
    step_wheels(4'b0011, 4'b1100, 4'h0);
    step_wheels(4'h0, 4'h0, 4'b0101);
    step_wheels(4'b0101, 4'h0, 4'b1010);
    read_counts();
    // A read right after a read reports a cleared decoder.
    read_counts();
    // Pin fields on a read are ignored and the stored levels are kept, so
    // resampling the old levels afterwards is no movement.
    send_item(FUNC_READ, ~pin_a, ~pin_b);
    sample_pins(pin_a, pin_b);
    step_wheels(4'hF, 4'h0, 4'h0);
    sample_pins(4'h0, 4'h0);
    sample_pins(4'hF, 4'hF);
    read_counts();

    // Random phases, each with its own idle pattern and a newly written mask.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 32;
          recv_idle_pct = 55;
          write_mask(4'h0);
        end
        1: begin
          send_idle_pct = 55;
          recv_idle_pct = 32;
          write_mask(4'hF);
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          write_mask(MaskW'($urandom));
          // Hold the result side off while reads keep coming, so that the
          // output register fills and the input has to stall.
          hold_asked++;
          repeat (10) begin
            read_counts();
            step_wheels(4'hF, 4'h0, 4'h0);
          end
        end
      endcase
      repeat (PHASE_ITEMS) random_item();
    end

    // Drain: all reports in, then a wait for anything late.
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ quad_wheel_quadrature_decoder_core.f @@
hw/rtl/qwd_pkg.sv
hw/rtl/qwd_wheel.sv
hw/rtl/qwd_report.sv
hw/rtl/quad_wheel_quadrature_decoder_core.sv
hw/rtl/qwd_checker.sv
test/qwd_count_checker.sv
test/tb_quad_wheel_quadrature_decoder_core.sv
